// ----- rtl/lzwe_pkg.sv -----
`default_nettype none

package lzwe_pkg;

  localparam int unsigned HASH_BITS     = 13;
  localparam int unsigned HASH_SLOTS    = 1 << HASH_BITS;
  localparam int unsigned MAX_CODE_BITS = 12;
  localparam int unsigned CODE_W        = 12;
  localparam int unsigned NEXT_W        = 13;
  localparam int unsigned WIDTH_W       = 4;
  localparam int unsigned TAG_W         = 8;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CODE_W-1:0]  CODE_CLEAR = CODE_W'(256);
  localparam logic [CODE_W-1:0]  CODE_END   = CODE_W'(257);
  localparam logic [NEXT_W-1:0]  CODE_FIRST = NEXT_W'(258);
  localparam logic [WIDTH_W-1:0] WIDTH_MIN  = WIDTH_W'(9);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX  = WIDTH_W'(MAX_CODE_BITS);
  localparam logic [TAG_W-1:0]   TAG_FIRST  = TAG_W'(1);
  localparam logic [TAG_W-1:0]   TAG_LAST   = '1;
  // no pending-queue push may start unless this many slots are occupied or fewer
  localparam logic [FIFO_CNT_W-1:0] FIFO_ACCEPT_MAX = FIFO_CNT_W'(FIFO_DEPTH - 2);

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // one code to pack; flush pads the tail and marks the final item
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] width;
    logic               flush;
  } cmd_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] prefix;
    logic [7:0]        sym;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam int unsigned CMD_W   = $bits(cmd_t);

  typedef enum logic [2:0] {
    F_SWEEP,
    F_IDLE,
    F_LOOK,
    F_CLEAR,
    F_FIN_END
  } front_state_e;

  function automatic logic [HASH_BITS-1:0] hash_slot(logic [CODE_W-1:0] prefix,
                                                     logic [7:0] sym);
    logic [CODE_W+7:0] key;
    key = {prefix, sym};
    return HASH_BITS'(key) ^ HASH_BITS'(key >> HASH_BITS);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lzwe_ram.sv -----
`default_nettype none

module lzwe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/lzwe_cmd_fifo.sv -----
`default_nettype none

module lzwe_cmd_fifo (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  input  wire lzwe_pkg::cmd_t                    wdata_i,
  input  wire logic                              pop_i,
  output      lzwe_pkg::cmd_t                    rdata_o,
  output      logic                              valid_o,
  output      logic [lzwe_pkg::FIFO_CNT_W-1:0]   count_o
);

  localparam int unsigned PTR_W = $clog2(lzwe_pkg::FIFO_DEPTH);

  lzwe_pkg::cmd_t mem_q [lzwe_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [lzwe_pkg::FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + PTR_W'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + PTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + lzwe_pkg::FIFO_CNT_W'(push_i) - lzwe_pkg::FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lzwe_back.sv -----
`default_nettype none

module lzwe_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lzwe_pkg::cmd_t      cmd_i,
  input  wire logic                cmd_valid_i,
  output      logic                cmd_pop_o,
  output      lzwe_pkg::out_item_t out_o,
  output      logic                empty,
  input  wire logic                pop
);

  logic [23:0] buf_q, buf_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        flush_q, flush_d;
  logic        outv_q, outv_d;
  lzwe_pkg::out_item_t out_q, out_d;
  logic        slot_free;
  logic [15:0] mask;

  assign slot_free = !outv_q || pop;
  assign cmd_pop_o = !busy_q && cmd_valid_i;
  assign empty     = !outv_q;
  assign out_o     = out_q;
  assign mask      = (16'd1 << cmd_i.width) - 16'd1;

  always_comb begin
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    flush_d = flush_q;
    out_d   = out_q;
    outv_d  = outv_q && !pop;
    if (cmd_pop_o) begin
      buf_d   = (buf_q << cmd_i.width) | 24'(16'(cmd_i.code) & mask);
      cnt_d   = cnt_q + 5'(cmd_i.width);
      busy_d  = 1'b1;
      flush_d = cmd_i.flush;
    end else if (busy_q && slot_free) begin
      if (cnt_q >= 5'd8) begin
        out_d.out_byte = 8'(buf_q >> (cnt_q - 5'd8));
        out_d.last     = flush_q && (cnt_q == 5'd8);
        outv_d         = 1'b1;
        cnt_d          = cnt_q - 5'd8;
      end else if (flush_q && cnt_q != 5'd0) begin
        // zero-padded tail
        out_d.out_byte = 8'(buf_q << (5'd8 - cnt_q));
        out_d.last     = 1'b1;
        outv_d         = 1'b1;
        cnt_d          = 5'd0;
        buf_d          = '0;
      end else begin
        busy_d = 1'b0;
        if (flush_q) begin
          buf_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      flush_q <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
      flush_q <= flush_d;
      outv_q  <= outv_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lzwe_front.sv -----
`default_nettype none

module lzwe_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output      logic                            full,
  input  wire lzwe_pkg::in_item_t              in_i,
  input  wire logic                            early_i,
  input  wire logic [lzwe_pkg::FIFO_CNT_W-1:0] fifo_count_i,
  output      logic                            cmd_push_o,
  output      lzwe_pkg::cmd_t                  cmd_o
);

  localparam int unsigned CW = lzwe_pkg::CODE_W;
  localparam int unsigned HB = lzwe_pkg::HASH_BITS;

  lzwe_pkg::front_state_e state_q, state_d;
  logic [CW-1:0]                   prefix_q, prefix_d;
  logic                            pvalid_q, pvalid_d;
  logic [lzwe_pkg::NEXT_W-1:0]     next_code_q, next_code_d;
  logic [lzwe_pkg::WIDTH_W-1:0]    width_q, width_d;
  logic [HB-1:0]                   slot_q, slot_d;
  logic [7:0]                      sym_q, sym_d;
  logic [lzwe_pkg::TAG_W-1:0]      epoch_q, epoch_d;
  logic [HB-1:0]                   sweep_q, sweep_d;

  logic                            ram_we;
  logic [HB-1:0]                   ram_waddr, ram_raddr;
  lzwe_pkg::entry_t                ram_wdata, rd;
  logic                            accept, entry_empty, entry_hit;
  logic                            wrap_now, grow_now, epoch_full;
  logic [15:0]                     span, last16;

  lzwe_ram #(
    .WIDTH (lzwe_pkg::ENTRY_W),
    .DEPTH (lzwe_pkg::HASH_SLOTS)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  assign full        = (state_q != lzwe_pkg::F_IDLE) || (fifo_count_i > lzwe_pkg::FIFO_ACCEPT_MAX);
  assign accept      = push && !full;
  // stale tag or an all-zero entry both count as an empty slot
  assign entry_empty = (rd.tag != epoch_q) || ({rd.code, rd.prefix, rd.sym} == '0);
  assign entry_hit   = !entry_empty && (rd.prefix == prefix_q) && (rd.sym == sym_q);
  assign span        = 16'd1 << width_q;
  assign last16      = 16'(next_code_q);
  assign wrap_now    = (last16 + 16'(early_i) + 16'd1 == span) && (width_q == lzwe_pkg::WIDTH_MAX);
  assign grow_now    = (last16 + 16'(early_i) == span);
  assign epoch_full  = (epoch_q == lzwe_pkg::TAG_LAST);

  always_comb begin
    state_d = state_q;
    case (state_q)
      lzwe_pkg::F_SWEEP: begin
        if (sweep_q == '1) state_d = lzwe_pkg::F_IDLE;
      end
      lzwe_pkg::F_IDLE: begin
        if (accept) begin
          if (in_i.kind) state_d = lzwe_pkg::F_FIN_END;
          else if (!pvalid_q) state_d = epoch_full ? lzwe_pkg::F_SWEEP : lzwe_pkg::F_IDLE;
          else state_d = lzwe_pkg::F_LOOK;
        end
      end
      lzwe_pkg::F_LOOK: begin
        if (entry_hit) state_d = lzwe_pkg::F_IDLE;
        else if (entry_empty) state_d = wrap_now ? lzwe_pkg::F_CLEAR : lzwe_pkg::F_IDLE;
      end
      lzwe_pkg::F_CLEAR, lzwe_pkg::F_FIN_END: begin
        state_d = epoch_full ? lzwe_pkg::F_SWEEP : lzwe_pkg::F_IDLE;
      end
      default: state_d = lzwe_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    prefix_d    = prefix_q;
    pvalid_d    = pvalid_q;
    next_code_d = next_code_q;
    width_d     = width_q;
    slot_d      = slot_q;
    sym_d       = sym_q;
    epoch_d     = epoch_q;
    sweep_d     = sweep_q;
    ram_we      = 1'b0;
    ram_waddr   = slot_q;
    ram_wdata   = '0;
    ram_raddr   = slot_q;
    cmd_push_o  = 1'b0;
    cmd_o       = '{code: prefix_q, width: width_q, flush: 1'b0};
    case (state_q)
      lzwe_pkg::F_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        sweep_d   = sweep_q + HB'(1);
        if (sweep_q == '1) epoch_d = lzwe_pkg::TAG_FIRST;
      end
      lzwe_pkg::F_IDLE: begin
        if (accept) begin
          sym_d = in_i.data_byte;
          if (in_i.kind) begin
            cmd_push_o = pvalid_q;
          end else if (!pvalid_q) begin
            cmd_push_o  = 1'b1;
            cmd_o.code  = lzwe_pkg::CODE_CLEAR;
            next_code_d = lzwe_pkg::CODE_FIRST;
            width_d     = lzwe_pkg::WIDTH_MIN;
            if (!epoch_full) epoch_d = epoch_q + lzwe_pkg::TAG_W'(1);
            prefix_d    = CW'(in_i.data_byte);
            pvalid_d    = 1'b1;
          end else begin
            ram_raddr = lzwe_pkg::hash_slot(prefix_q, in_i.data_byte);
            slot_d    = ram_raddr;
          end
        end
      end
      lzwe_pkg::F_LOOK: begin
        if (entry_hit) begin
          prefix_d = rd.code;
        end else if (entry_empty) begin
          ram_we      = 1'b1;
          ram_wdata   = '{tag: epoch_q, code: CW'(next_code_q), prefix: prefix_q, sym: sym_q};
          next_code_d = next_code_q + lzwe_pkg::NEXT_W'(1);
          cmd_push_o  = 1'b1;
          prefix_d    = CW'(sym_q);
          if (!wrap_now && grow_now) width_d = width_q + lzwe_pkg::WIDTH_W'(1);
        end else begin
          slot_d    = slot_q + HB'(1);
          ram_raddr = slot_d;
        end
      end
      lzwe_pkg::F_CLEAR: begin
        cmd_push_o  = 1'b1;
        cmd_o.code  = lzwe_pkg::CODE_CLEAR;
        next_code_d = lzwe_pkg::CODE_FIRST;
        width_d     = lzwe_pkg::WIDTH_MIN;
        if (!epoch_full) epoch_d = epoch_q + lzwe_pkg::TAG_W'(1);
      end
      lzwe_pkg::F_FIN_END: begin
        cmd_push_o  = 1'b1;
        cmd_o.code  = lzwe_pkg::CODE_END;
        cmd_o.flush = 1'b1;
        next_code_d = lzwe_pkg::CODE_FIRST;
        width_d     = lzwe_pkg::WIDTH_MIN;
        if (!epoch_full) epoch_d = epoch_q + lzwe_pkg::TAG_W'(1);
        prefix_d    = '0;
        pvalid_d    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    sym_q  <= sym_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lzwe_pkg::F_SWEEP;
      prefix_q    <= '0;
      pvalid_q    <= 1'b0;
      next_code_q <= lzwe_pkg::CODE_FIRST;
      width_q     <= lzwe_pkg::WIDTH_MIN;
      epoch_q     <= lzwe_pkg::TAG_FIRST;
      sweep_q     <= '0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      pvalid_q    <= pvalid_d;
      next_code_q <= next_code_d;
      width_q     <= width_d;
      epoch_q     <= epoch_d;
      sweep_q     <= sweep_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_look_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lzwe_pkg::F_LOOK |->
      $past(state_q) == lzwe_pkg::F_IDLE || $past(state_q) == lzwe_pkg::F_LOOK)
    else $error("probe state entered from wrong state");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.kind |=> state_q == lzwe_pkg::F_FIN_END)
    else $error("finish item not followed by end code");
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_q >= lzwe_pkg::WIDTH_MIN)
    else $error("code width below minimum");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push_o |-> fifo_count_i != lzwe_pkg::FIFO_CNT_W'(lzwe_pkg::FIFO_DEPTH))
    else $error("code queue overflow");
`endif

endmodule

`default_nettype wire

// ----- rtl/lzw_encoder_variable_width.sv -----
// LZW encoder, 9 to 12 bit codes, MSB-first byte packing.
// Input channel (push/full): one item is a data byte or a finish marker.
// Output channel (empty/pop): packed code bytes; last marks the final byte
// of a finished stream. Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i)
// sets early_change; it is always ready and should be written while idle.
// A data byte is handled in the idle state when no prefix is held; otherwise
// it is looked up in the dictionary, probing successive slots of the chain
// (one read of the dictionary RAM per cycle), and a full table restarts.
// A finish marker passes through the end-code state in the front end.
// Codes pass through a 4-entry queue to the packer, which writes one byte
// per cycle into the output register while that register is free; the packer
// loads one code, sends out its whole bytes and only then takes the next code.
// After reset, and on every 255th table restart (a finish counts as one),
// all 8192 dictionary slots are swept to stale tags while full stays high.
// If the receiver stalls, bytes wait in the output register and codes in the
// queue; the front end keeps taking items until the code queue is nearly full.
`default_nettype none

module lzw_encoder_variable_width (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output      logic                full,
  input  wire lzwe_pkg::in_item_t  in_i,
  output      logic                empty,
  input  wire logic                pop,
  output      lzwe_pkg::out_item_t out_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic                cfg_data_i
);

  logic early_q;
  logic fifo_push, fifo_pop, fifo_valid;
  lzwe_pkg::cmd_t fifo_wdata, fifo_rdata;
  logic [lzwe_pkg::FIFO_CNT_W-1:0] fifo_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      early_q <= cfg_data_i;
    end
  end

  lzwe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_i         (in_i),
    .early_i      (early_q),
    .fifo_count_i (fifo_count),
    .cmd_push_o   (fifo_push),
    .cmd_o        (fifo_wdata)
  );

  lzwe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (fifo_wdata),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_rdata),
    .valid_o (fifo_valid),
    .count_o (fifo_count)
  );

  lzwe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fifo_rdata),
    .cmd_valid_i (fifo_valid),
    .cmd_pop_o   (fifo_pop),
    .out_o       (out_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

`default_nettype wire
